// ===== rtl/core/sacl_pkg.sv =====
// Shared types, constants and helpers for the set-associative cache lookup.
// No dependencies; every other file in rtl/core refers to this package.
package sacl_pkg;

    localparam int MAX_LINES_DEF = 256;
    localparam int MAX_WAYS_DEF  = 8;
    localparam int ADDR_BITS     = 15;
    localparam int SET_W         = 8;
    localparam int USED_W        = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 4;
    localparam int WAY_FIELD_MAX = 3;

    localparam logic POLICY_LRU = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_SIZE = 3'd0,
        REG_SET_COUNT  = 3'd1,
        REG_WAY_COUNT  = 3'd2,
        REG_MEM_SIZE   = 3'd3,
        REG_POLICY     = 3'd4
    } cfg_reg_t;

    // geometry after limiting to the line store
    typedef struct packed {
        logic [3:0] block_log2;
        logic [3:0] set_log2;
        logic [1:0] way_log2;
        logic [3:0] mem_log2;
        logic       policy;
    } geom_t;

    typedef struct packed {
        logic valid_set;
        logic block_we;
        logic dirty_we;
        logic rank_we;
    } lines_wr_t;

    function automatic int flog2(input int v);
        int n;
        int x;
        n = 0;
        x = v;
        while (x > 1) begin
            x = x >> 1;
            n++;
        end
        return n;
    endfunction

    function automatic int way_log2_cap(input int max_ways, input int max_lines);
        int c;
        c = flog2(max_ways);
        if (flog2(max_lines) < c)
            c = flog2(max_lines);
        if (WAY_FIELD_MAX < c)
            c = WAY_FIELD_MAX;
        return c;
    endfunction

endpackage

// ===== rtl/core/sacl_cfg.sv =====
// Configuration registers and geometry limiting for the cache lookup.
// Depends on sacl_pkg.
module sacl_cfg #(
    parameter int MAX_LINES = sacl_pkg::MAX_LINES_DEF,
    parameter int MAX_WAYS  = sacl_pkg::MAX_WAYS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]  cfg_data,
    output sacl_pkg::geom_t                  geom
);

    localparam int LL  = sacl_pkg::flog2(MAX_LINES);
    localparam int WLC = sacl_pkg::way_log2_cap(MAX_WAYS, MAX_LINES);

    logic [3:0] block_log2_reg;
    logic [3:0] set_log2_reg;
    logic [1:0] way_log2_reg;
    logic [3:0] mem_log2_reg;
    logic       policy_reg;
    logic [3:0] wl_lim;
    logic [3:0] sl_lim;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_log2_reg <= 4'd2;
            set_log2_reg   <= 4'd2;
            way_log2_reg   <= 2'd1;
            mem_log2_reg   <= 4'd15;
            policy_reg     <= sacl_pkg::POLICY_LRU;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sacl_pkg::REG_BLOCK_SIZE: block_log2_reg <= cfg_data;
                sacl_pkg::REG_SET_COUNT:  set_log2_reg   <= cfg_data;
                sacl_pkg::REG_WAY_COUNT:  way_log2_reg   <= cfg_data[1:0];
                sacl_pkg::REG_MEM_SIZE:   mem_log2_reg   <= cfg_data;
                sacl_pkg::REG_POLICY:     policy_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        wl_lim = ({2'b00, way_log2_reg} > 4'(WLC)) ? 4'(WLC) : {2'b00, way_log2_reg};
        sl_lim = (set_log2_reg > 4'd8) ? 4'd8 : set_log2_reg;
        if (({1'b0, sl_lim} + {1'b0, wl_lim}) > 5'(LL))
            sl_lim = 4'(5'(LL) - {1'b0, wl_lim});
        geom.block_log2 = block_log2_reg;
        geom.set_log2   = sl_lim;
        geom.way_log2   = wl_lim[1:0];
        geom.mem_log2   = mem_log2_reg;
        geom.policy     = policy_reg;
    end

endmodule

// ===== rtl/core/sacl_lines.sv =====
// Line store: block, dirty and age-rank memories plus per-line valid flags.
// Depends on sacl_pkg.
module sacl_lines #(
    parameter int MAX_LINES = sacl_pkg::MAX_LINES_DEF,
    parameter int MAX_WAYS  = sacl_pkg::MAX_WAYS_DEF,
    localparam int LL  = sacl_pkg::flog2(MAX_LINES),
    localparam int LIW = (LL > 0) ? LL : 1,
    localparam int WLC = sacl_pkg::way_log2_cap(MAX_WAYS, MAX_LINES),
    localparam int RW  = (WLC > 0) ? WLC : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [LIW-1:0]                 rd_idx,
    output logic                           rd_valid,
    output logic [sacl_pkg::ADDR_BITS-1:0] rd_block,
    output logic [RW-1:0]                  rd_rank,
    input  sacl_pkg::lines_wr_t            wr,
    input  logic [LIW-1:0]                 wr_idx,
    input  logic [sacl_pkg::ADDR_BITS-1:0] wr_block,
    input  logic                           wr_dirty,
    input  logic [RW-1:0]                  wr_rank
);

    localparam int DEPTH = 1 << LL;

    logic                           valid_reg [DEPTH];
    logic [sacl_pkg::ADDR_BITS-1:0] block_mem [DEPTH];
    logic                           dirty_mem [DEPTH];
    logic [RW-1:0]                  rank_mem  [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                valid_reg[i] <= 1'b0;
            rd_valid <= 1'b0;
        end
        else
        begin
            rd_valid <= valid_reg[rd_idx];
            if (wr.valid_set)
                valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_block <= block_mem[rd_idx];
        rd_rank  <= rank_mem[rd_idx];
        if (wr.block_we)
            block_mem[wr_idx] <= wr_block;
        if (wr.dirty_we)
            dirty_mem[wr_idx] <= wr_dirty;
        if (wr.rank_we)
            rank_mem[wr_idx] <= wr_rank;
    end

endmodule

// ===== rtl/core/sacl_seq.sv =====
// Lookup sequencer: serial way walk through one compare unit, then rank update.
// Depends on sacl_pkg; drives the sacl_lines ports.
module sacl_seq #(
    parameter int MAX_LINES = sacl_pkg::MAX_LINES_DEF,
    parameter int MAX_WAYS  = sacl_pkg::MAX_WAYS_DEF,
    localparam int LL  = sacl_pkg::flog2(MAX_LINES),
    localparam int LIW = (LL > 0) ? LL : 1,
    localparam int WLC = sacl_pkg::way_log2_cap(MAX_WAYS, MAX_LINES),
    localparam int RW  = (WLC > 0) ? WLC : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sacl_pkg::geom_t                geom,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           mode,
    input  logic [sacl_pkg::ADDR_BITS-1:0] address,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           hit,
    output logic                           address_error,
    output logic [sacl_pkg::ADDR_BITS-1:0] memory_block,
    output logic [sacl_pkg::SET_W-1:0]     cache_set,
    output logic [sacl_pkg::USED_W-1:0]    line_used,
    output logic [LIW-1:0]                 rd_idx,
    input  logic                           rd_valid,
    input  logic [sacl_pkg::ADDR_BITS-1:0] rd_block,
    input  logic [RW-1:0]                  rd_rank,
    output sacl_pkg::lines_wr_t            wr,
    output logic [LIW-1:0]                 wr_idx,
    output logic [sacl_pkg::ADDR_BITS-1:0] wr_block,
    output logic                           wr_dirty,
    output logic [RW-1:0]                  wr_rank
);

    localparam int WIW      = (WLC > 0) ? WLC : 1;
    localparam int CW       = WLC + 1;
    localparam int WAYS_MAX = 1 << WLC;
    localparam int BW       = LIW + sacl_pkg::SET_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_UPD,
        ST_DONE
    } state_t;

    state_t                         state_reg;
    logic                           mode_reg;
    logic [LIW-1:0]                 base_reg;
    logic [CW-1:0]                  cnt_reg;
    logic                           pend_reg;
    logic [WIW-1:0]                 pw_reg;
    logic [CW-1:0]                  vcount_reg;
    logic                           match_f_reg;
    logic [WIW-1:0]                 match_way_reg;
    logic [RW-1:0]                  match_rank_reg;
    logic                           free_f_reg;
    logic [WIW-1:0]                 free_way_reg;
    logic [WIW-1:0]                 vic_way_reg;
    logic [RW-1:0]                  vic_rank_reg;
    logic [RW-1:0]                  rank_buf_reg  [WAYS_MAX];
    logic                           valid_buf_reg [WAYS_MAX];
    logic [WIW-1:0]                 tgt_reg;
    logic [RW-1:0]                  ref_rank_reg;
    logic [RW-1:0]                  new_rank_reg;
    logic                           dec_reg;
    logic                           hit_reg;
    logic                           err_reg;
    logic [sacl_pkg::ADDR_BITS-1:0] blk_reg;
    logic [sacl_pkg::SET_W-1:0]     set_reg;
    logic [sacl_pkg::USED_W-1:0]    used_reg;

    logic [CW-1:0]                  ways;
    logic [sacl_pkg::ADDR_BITS-1:0] blk_in;
    logic [sacl_pkg::SET_W-1:0]     set_in;
    logic [BW-1:0]                  base_wide;
    logic                           err_in;
    logic                           way_match;
    logic                           last_way;
    logic [WIW-1:0]                 k_way;
    logic [LIW-1:0]                 tgt_line;

    assign ways      = CW'(1) << geom.way_log2;
    assign blk_in    = sacl_pkg::ADDR_BITS'(address >> geom.block_log2);
    assign set_in    = blk_in[sacl_pkg::SET_W-1:0]
                     & 8'((9'd1 << geom.set_log2) - 9'd1);
    assign base_wide = BW'(set_in) << geom.way_log2;
    assign err_in    = (address >> geom.mem_log2) != '0;
    assign way_match = rd_valid && (rd_block == blk_reg);
    assign last_way  = CW'(pw_reg) == (ways - CW'(1));
    assign k_way     = cnt_reg[WIW-1:0];

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = (state_reg == ST_DONE);
    assign hit           = hit_reg;
    assign address_error = err_reg;
    assign memory_block  = blk_reg;
    assign cache_set     = set_reg;
    assign line_used     = used_reg;

    assign rd_idx = base_reg + LIW'(cnt_reg);

    always_comb
    begin
        wr       = '0;
        wr_idx   = base_reg + LIW'(k_way);
        wr_block = blk_reg;
        wr_dirty = mode_reg;
        wr_rank  = new_rank_reg;
        tgt_line = base_reg + LIW'(vic_way_reg);
        if (match_f_reg)
            tgt_line = base_reg + LIW'(match_way_reg);
        else if (free_f_reg)
            tgt_line = base_reg + LIW'(free_way_reg);
        unique case (state_reg)
            ST_PICK:
            begin
                wr_idx = tgt_line;
                if (match_f_reg)
                begin
                    wr.dirty_we = (geom.policy == sacl_pkg::POLICY_LRU);
                end
                else if (free_f_reg)
                begin
                    wr.valid_set = 1'b1;
                    wr.block_we  = 1'b1;
                    wr.dirty_we  = 1'b1;
                    wr.rank_we   = 1'b1;
                    wr_rank      = RW'(vcount_reg);
                end
                else
                begin
                    wr.block_we = 1'b1;
                    wr.dirty_we = 1'b1;
                end
            end
            ST_UPD:
            begin
                if (k_way == tgt_reg)
                begin
                    wr.rank_we = 1'b1;
                end
                else if (dec_reg && valid_buf_reg[k_way]
                         && (rank_buf_reg[k_way] > ref_rank_reg))
                begin
                    wr.rank_we = 1'b1;
                    wr_rank    = rank_buf_reg[k_way] - RW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        mode_reg    <= mode;
                        blk_reg     <= blk_in;
                        set_reg     <= set_in;
                        base_reg    <= base_wide[LIW-1:0];
                        cnt_reg     <= '0;
                        pend_reg    <= 1'b0;
                        vcount_reg  <= '0;
                        match_f_reg <= 1'b0;
                        free_f_reg  <= 1'b0;
                        hit_reg     <= 1'b0;
                        err_reg     <= err_in;
                        used_reg    <= '0;
                        state_reg   <= err_in ? ST_DONE : ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (cnt_reg < ways)
                    begin
                        pend_reg <= 1'b1;
                        pw_reg   <= cnt_reg[WIW-1:0];
                        cnt_reg  <= cnt_reg + CW'(1);
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg)
                    begin
                        rank_buf_reg[pw_reg]  <= rd_rank;
                        valid_buf_reg[pw_reg] <= rd_valid;
                        if (rd_valid)
                            vcount_reg <= vcount_reg + CW'(1);
                        if (way_match && !match_f_reg)
                        begin
                            match_f_reg    <= 1'b1;
                            match_way_reg  <= pw_reg;
                            match_rank_reg <= rd_rank;
                        end
                        if (!rd_valid && !free_f_reg)
                        begin
                            free_f_reg   <= 1'b1;
                            free_way_reg <= pw_reg;
                        end
                        if ((pw_reg == '0) || (rd_rank < vic_rank_reg))
                        begin
                            vic_way_reg  <= pw_reg;
                            vic_rank_reg <= rd_rank;
                        end
                        if (last_way)
                            state_reg <= ST_PICK;
                    end
                end
                ST_PICK:
                begin
                    cnt_reg  <= '0;
                    used_reg <= sacl_pkg::USED_W'(tgt_line);
                    if (match_f_reg)
                    begin
                        hit_reg        <= 1'b1;
                        tgt_reg        <= match_way_reg;
                        ref_rank_reg   <= match_rank_reg;
                        new_rank_reg   <= RW'(vcount_reg - CW'(1));
                        dec_reg        <= 1'b1;
                        state_reg      <= (geom.policy == sacl_pkg::POLICY_LRU)
                                        ? ST_UPD : ST_DONE;
                    end
                    else if (free_f_reg)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        tgt_reg      <= vic_way_reg;
                        ref_rank_reg <= vic_rank_reg;
                        new_rank_reg <= RW'(ways - CW'(1));
                        dec_reg      <= 1'b1;
                        state_reg    <= ST_UPD;
                    end
                end
                ST_UPD:
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == (ways - CW'(1)))
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_stall)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/set_associative_cache_lookup_top.sv =====
// Top level of the set-associative cache lookup with LRU or FIFO replacement.
// Depends on sacl_pkg, sacl_cfg, sacl_lines and sacl_seq.
//
// One item is handled at a time. An item whose address lies outside the
// configured memory size has its result presented in the cycle after
// acceptance. Any other item walks the W ways of its set serially through
// the line store's single read port, picks the way, writes back the age
// ranks on an LRU hit or an eviction (not on a fill into a free way or a
// FIFO hit), and presents the result. The result then waits until taken,
// and the next item is accepted in the cycle after. Line valid flags clear
// at reset, so no clearing pass is needed.
module set_associative_cache_lookup_top #(
    parameter int MAX_LINES = sacl_pkg::MAX_LINES_DEF,
    parameter int MAX_WAYS  = sacl_pkg::MAX_WAYS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            mode,
    input  logic [sacl_pkg::ADDR_BITS-1:0]  address,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            hit,
    output logic                            address_error,
    output logic [sacl_pkg::ADDR_BITS-1:0]  memory_block,
    output logic [sacl_pkg::SET_W-1:0]      cache_set,
    output logic [sacl_pkg::USED_W-1:0]     line_used,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int LL  = sacl_pkg::flog2(MAX_LINES);
    localparam int LIW = (LL > 0) ? LL : 1;
    localparam int WLC = sacl_pkg::way_log2_cap(MAX_WAYS, MAX_LINES);
    localparam int RW  = (WLC > 0) ? WLC : 1;

    sacl_pkg::geom_t                geom;
    sacl_pkg::lines_wr_t            wr;
    logic [LIW-1:0]                 rd_idx;
    logic                           rd_valid;
    logic [sacl_pkg::ADDR_BITS-1:0] rd_block;
    logic [RW-1:0]                  rd_rank;
    logic [LIW-1:0]                 wr_idx;
    logic [sacl_pkg::ADDR_BITS-1:0] wr_block;
    logic                           wr_dirty;
    logic [RW-1:0]                  wr_rank;

    sacl_cfg #(
        .MAX_LINES (MAX_LINES),
        .MAX_WAYS  (MAX_WAYS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    sacl_lines #(
        .MAX_LINES (MAX_LINES),
        .MAX_WAYS  (MAX_WAYS)
    ) u_lines (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_idx   (rd_idx),
        .rd_valid (rd_valid),
        .rd_block (rd_block),
        .rd_rank  (rd_rank),
        .wr       (wr),
        .wr_idx   (wr_idx),
        .wr_block (wr_block),
        .wr_dirty (wr_dirty),
        .wr_rank  (wr_rank)
    );

    sacl_seq #(
        .MAX_LINES (MAX_LINES),
        .MAX_WAYS  (MAX_WAYS)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .geom          (geom),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .address       (address),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .address_error (address_error),
        .memory_block  (memory_block),
        .cache_set     (cache_set),
        .line_used     (line_used),
        .rd_idx        (rd_idx),
        .rd_valid      (rd_valid),
        .rd_block      (rd_block),
        .rd_rank       (rd_rank),
        .wr            (wr),
        .wr_idx        (wr_idx),
        .wr_block      (wr_block),
        .wr_dirty      (wr_dirty),
        .wr_rank       (wr_rank)
    );

endmodule

// ===== tb/sv/set_associative_cache_lookup_top_tb.sv =====
// Self-checking testbench for set_associative_cache_lookup_top: a mirror of the cache lines
// predicts every lookup result across LRU/FIFO and a range of geometries.
// Depends on sacl_pkg and the RTL top level only.
module set_associative_cache_lookup_top_tb;

    import sacl_pkg::*;

    localparam logic ACC_READ    = 1'b0;
    localparam logic ACC_WRITE   = 1'b1;
    localparam logic POLICY_FIFO = 1'b1;
    localparam int   LIMIT       = 1000000;
    localparam int   ITEMS_PER_PHASE = 108;

    typedef struct packed {
        logic                 hit;
        logic                 address_error;
        logic [ADDR_BITS-1:0] memory_block;
        logic [SET_W-1:0]     cache_set;
        logic [USED_W-1:0]    line_used;
    } lookup_result_t;

    class cache_lookup_checker;
        bit                   present [256];
        bit                   dirty_mark [256];
        logic [ADDR_BITS-1:0] tag_block [256];
        logic [2:0]           age [256];
        int unsigned          blk_log2;
        int unsigned          set_log2;
        int unsigned          way_log2;
        int unsigned          mem_log2;
        bit                   fifo;
        lookup_result_t       expected_lookups [$];
        int                   failures;

        function new();
            foreach (present[i])
            begin
                present[i]    = 1'b0;
                dirty_mark[i] = 1'b0;
                tag_block[i]  = '0;
                age[i]        = '0;
            end
            blk_log2 = 2;
            set_log2 = 2;
            way_log2 = 1;
            mem_log2 = 15;
            fifo     = POLICY_LRU;
            failures = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_BLOCK_SIZE: blk_log2 = 32'(d);
                REG_SET_COUNT:  set_log2 = 32'(d);
                REG_WAY_COUNT:  way_log2 = 32'(d[1:0]);
                REG_MEM_SIZE:   mem_log2 = 32'(d);
                REG_POLICY:     fifo     = d[0];
                default: ;
            endcase
        endfunction

        // set and way bits share the 8 bits of line index
        function void geometry(output int unsigned sl, output int unsigned wl);
            wl = way_log2;
            sl = (set_log2 > 8) ? 8 : set_log2;
            if (sl + wl > 8)
                sl = 8 - wl;
        endfunction

        function int unsigned line_count();
            int unsigned sl;
            int unsigned wl;
            geometry(sl, wl);
            return (1 << sl) << wl;
        endfunction

        function void note_access(logic m, logic [ADDR_BITS-1:0] a);
            int unsigned    sl;
            int unsigned    wl;
            int unsigned    ways;
            int unsigned    blk;
            int unsigned    set_idx;
            int unsigned    base;
            int unsigned    valid_cnt;
            int unsigned    used;
            int unsigned    victim;
            int unsigned    j;
            int             hit_way;
            int             free_way;
            logic [2:0]     r;
            lookup_result_t res;
            geometry(sl, wl);
            ways    = 1 << wl;
            blk     = 32'(a) >> blk_log2;
            set_idx = blk & ((1 << sl) - 1);
            base    = set_idx * ways;
            res     = '0;
            res.memory_block = blk[ADDR_BITS-1:0];
            res.cache_set    = set_idx[SET_W-1:0];
            if ((32'(a) >> mem_log2) != 0)
            begin
                res.address_error = 1'b1;
                expected_lookups.push_back(res);
                return;
            end
            hit_way   = -1;
            free_way  = -1;
            valid_cnt = 0;
            for (int w = 0; w < ways; w++)
            begin
                j = base + w;
                if (present[j])
                begin
                    valid_cnt++;
                    if (hit_way < 0 && tag_block[j] == blk[ADDR_BITS-1:0])
                        hit_way = w;
                end
                else if (free_way < 0)
                    free_way = w;
            end
            if (hit_way >= 0)
            begin
                used    = base + hit_way;
                res.hit = 1'b1;
                if (fifo == POLICY_LRU)
                begin
                    r = age[used];
                    for (int w = 0; w < ways; w++)
                    begin
                        j = base + w;
                        if (present[j] && j != used && age[j] > r)
                            age[j]--;
                    end
                    age[used]        = 3'(valid_cnt - 1);
                    dirty_mark[used] = m;
                end
            end
            else if (free_way >= 0)
            begin
                used             = base + free_way;
                present[used]    = 1'b1;
                dirty_mark[used] = m;
                tag_block[used]  = blk[ADDR_BITS-1:0];
                age[used]        = 3'(valid_cnt);
            end
            else
            begin
                // full set: oldest goes, lowest way on a tie
                victim = base;
                for (int w = 1; w < ways; w++)
                    if (age[base + w] < age[victim])
                        victim = base + w;
                r = age[victim];
                for (int w = 0; w < ways; w++)
                begin
                    j = base + w;
                    if (j != victim && age[j] > r)
                        age[j]--;
                end
                used             = victim;
                present[used]    = 1'b1;
                dirty_mark[used] = m;
                tag_block[used]  = blk[ADDR_BITS-1:0];
                age[used]        = 3'(ways - 1);
            end
            res.line_used = used[USED_W-1:0];
            expected_lookups.push_back(res);
        endfunction

        function void check_result(logic h, logic e, logic [ADDR_BITS-1:0] b,
                                   logic [SET_W-1:0] s, logic [USED_W-1:0] u);
            lookup_result_t want;
            if (expected_lookups.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: hit=%0d err=%0d block=%0d set=%0d line=%0d",
                             h, e, b, s, u);
                return;
            end
            want = expected_lookups.pop_front();
            if (h !== want.hit || e !== want.address_error || b !== want.memory_block ||
                s !== want.cache_set || u !== want.line_used)
            begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: expected hit=%0d err=%0d block=%0d set=%0d line=%0d, %s",
                             want.hit, want.address_error, want.memory_block, want.cache_set,
                             want.line_used,
                             $sformatf("got hit=%0d err=%0d block=%0d set=%0d line=%0d",
                                       h, e, b, s, u));
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  mode = ACC_READ;
    logic [ADDR_BITS-1:0]  address = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  hit;
    logic                  address_error;
    logic [ADDR_BITS-1:0]  memory_block;
    logic [SET_W-1:0]      cache_set;
    logic [USED_W-1:0]     line_used;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_reg_t              cfg_index = REG_BLOCK_SIZE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    cache_lookup_checker   sb = new();
    int                    cycle_count = 0;
    int                    burst_left = 0;
    bit                    holding = 1'b0;
    int unsigned           block_salt = 0;
    int unsigned           stall_tick = 0;
    int unsigned           stall_style = 0;

    set_associative_cache_lookup_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .address       (address),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .address_error (address_error),
        .memory_block  (memory_block),
        .cache_set     (cache_set),
        .line_used     (line_used),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("** set_associative_cache_lookup_top: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_tick[6:0] == 0)
            stall_style <= $urandom_range(0, 3);
        case (stall_style)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(0, 1));
            2:       out_stall <= (stall_tick % 3 == 0);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(hit, address_error, memory_block, cache_set, line_used);

    task automatic send_item(input logic m, input logic [ADDR_BITS-1:0] a);
        int gap;
        mode     <= m;
        address  <= a;
        in_valid <= 1'b1;
        holding   = 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_access(m, a);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 4);
            gap        = $urandom_range(1, 12);
            in_valid  <= 1'b0;
            holding    = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic hold_until_idle();
        if (holding)
        begin
            in_valid <= 1'b0;
            holding   = 1'b0;
        end
        while (sb.expected_lookups.size() != 0)
            @(posedge clk);
        burst_left = 0;
    endtask

    task automatic configure(input int unsigned b, input int unsigned s, input int unsigned w,
                             input int unsigned m, input int unsigned p);
        cfg_reg_t    regs [5];
        int unsigned vals [5];
        regs = '{REG_BLOCK_SIZE, REG_SET_COUNT, REG_WAY_COUNT, REG_MEM_SIZE, REG_POLICY};
        vals = '{b, s, w, m, p};
        cfg_valid <= 1'b1;
        for (int i = 0; i < 5; i++)
        begin
            cfg_index <= regs[i];
            cfg_data  <= CFG_DATA_W'(vals[i]);
            do @(posedge clk); while (!cfg_ready);
            sb.write_reg(regs[i], CFG_DATA_W'(vals[i]));
        end
        cfg_valid <= 1'b0;
    endtask

    // mostly blocks from a pool a little larger than the cache, so hits and evictions both occur
    function automatic logic [ADDR_BITS-1:0] pick_address();
        int unsigned pool;
        int unsigned blk;
        int unsigned off;
        if ($urandom_range(0, 9) == 0)
            return ADDR_BITS'($urandom_range(0, 32767));
        pool = (sb.line_count() * 3) / 2 + 1;
        blk  = $urandom_range(0, pool - 1) + block_salt;
        off  = $urandom & ((1 << sb.blk_log2) - 1);
        return ADDR_BITS'(((blk << sb.blk_log2) | off) & ((1 << sb.mem_log2) - 1));
    endfunction

    task automatic run_phase(input int unsigned b, input int unsigned s, input int unsigned w,
                             input int unsigned m, input int unsigned p);
        hold_until_idle();
        configure(b, s, w, m, p);
        block_salt = $urandom_range(0, 32767);
        for (int i = 0; i < ITEMS_PER_PHASE; i++)
        begin
            if ($urandom_range(0, 59) == 0)
                hold_until_idle();
            send_item(1'($urandom_range(0, 1)), pick_address());
        end
    endtask

    initial
    begin
        int unsigned fixed_settings [8][5];
        fixed_settings = '{'{0, 0, 0, 15, POLICY_LRU},  '{3, 3, 3, 15, POLICY_LRU},
                           '{3, 3, 3, 15, POLICY_FIFO}, '{15, 8, 3, 15, POLICY_FIFO},
                           '{0, 8, 0, 15, POLICY_LRU},  '{1, 5, 2, 12, POLICY_FIFO},
                           '{4, 8, 3, 15, POLICY_LRU},  '{2, 2, 1, 15, POLICY_LRU}};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 4 sets x 2 ways, 4-byte blocks, 1 KiB of memory
        configure(2, 2, 1, 10, POLICY_LRU);
        send_item(ACC_READ,  15'd0);
        send_item(ACC_WRITE, 15'd1);
        send_item(ACC_READ,  15'd16);
        send_item(ACC_READ,  15'd2);
        send_item(ACC_WRITE, 15'd32);
        send_item(ACC_READ,  15'd16);
        send_item(ACC_READ,  15'd1023);
        send_item(ACC_READ,  15'd1024);
        send_item(ACC_WRITE, 15'h7fff);
        send_item(ACC_READ,  15'd1020);
        hold_until_idle();
        configure(2, 2, 1, 10, POLICY_FIFO);
        send_item(ACC_READ,  15'd32);
        send_item(ACC_WRITE, 15'd16);
        send_item(ACC_READ,  15'd48);
        send_item(ACC_READ,  15'd64);
        send_item(ACC_READ,  15'd1023);
        send_item(ACC_WRITE, 15'd1024);
        hold_until_idle();
        configure(0, 0, 0, 0, POLICY_LRU);
        send_item(ACC_READ,  15'd0);
        send_item(ACC_WRITE, 15'd0);
        send_item(ACC_READ,  15'd1);
        hold_until_idle();
        configure(15, 8, 3, 15, POLICY_LRU);
        send_item(ACC_READ,  15'h7fff);
        send_item(ACC_WRITE, 15'd0);

        foreach (fixed_settings[i])
            run_phase(fixed_settings[i][0], fixed_settings[i][1], fixed_settings[i][2],
                      fixed_settings[i][3], fixed_settings[i][4]);
        for (int i = 0; i < 6; i++)
            run_phase(($urandom_range(0, 9) < 7) ? $urandom_range(0, 5) : $urandom_range(0, 15),
                      $urandom_range(0, 8), $urandom_range(0, 3),
                      ($urandom_range(0, 9) < 7) ? $urandom_range(10, 15) : $urandom_range(0, 15),
                      $urandom_range(0, 1));

        hold_until_idle();
        repeat (24) @(posedge clk);
        if (sb.failures == 0 && sb.expected_lookups.size() == 0)
            $display("** set_associative_cache_lookup_top: PASSED **");
        else
            $display("** set_associative_cache_lookup_top: FAILED **");
        $finish;
    end

endmodule
